// File: rtl/core/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

   // Default sizes and register limits
   localparam int DESCRIPTORS_DEF     = 32;
   localparam int ARENA_ADDR_BITS_DEF = 16;
   localparam int GUARD_MAX           = 16;
   localparam int GUARD_RESET         = 4;
   localparam int ARENA_RESET         = 65536;

   // Descriptor kinds
   typedef enum logic [1:0] {
      KIND_SPARE = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_ALLOC = 2'd2
   } kind_type;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Register indexes (taken from paddr bit 2)
   localparam logic REG_ARENA = 1'b0;
   localparam logic REG_GUARD = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ALIGN = 3'd1;
   localparam logic [2:0] ST_NO_DESC   = 3'd2;
   localparam logic [2:0] ST_NO_FIT    = 3'd3;
   localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CO_OUT = 6'b000010,
      S_CO_IN  = 6'b000100,
      S_FIT_A  = 6'b001000,
      S_FIT_B  = 6'b010000,
      S_FREE   = 6'b100000
   } state_type;

endpackage

// File: rtl/core/first_fit_heap_allocator_top.sv
// First-fit allocator over a descriptor pool with free-block coalescing.
// Bad alignment is answered in the cycle after start; an allocate walks the free list, aligning
//   and testing each block in turn (S_FIT_A, S_FIT_B), after a merge scan when no spare is left.
//   A free walks the allocated list block by block. One sequencer, one item at a time.
// Throughput: one item per result; busy stays high until the result strobe.
// Reset: synchronous; restores one free block covering the arena, guard 4. Results cannot stall.
module first_fit_heap_allocator_top #(
   parameter int DESCRIPTORS     = ffha_pkg::DESCRIPTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_request_bytes,
   input  logic [7:0]  req_alignment,
   input  logic [15:0] req_user_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_granted_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int D    = DESCRIPTORS;
   localparam int AW   = ffha_pkg::ARENA_ADDR_BITS_DEF;
   localparam int DW   = $clog2(D);
   localparam int CW   = $clog2(D + 1);
   localparam int BW   = AW + 1;
   localparam int NW   = ((BW > 17) ? BW : 17) + 1;
   localparam longint LIMIT = longint'(1) << AW;
   localparam longint ARENA_RST =
      (longint'(ffha_pkg::ARENA_RESET) > LIMIT) ? LIMIT : longint'(ffha_pkg::ARENA_RESET);

   // Configuration registers
   logic [BW-1:0] arena_ff, arena_in;
   logic [4:0]    guard_ff, guard_in;

   // Descriptor storage and list order
   logic [BW-1:0]      base_ff [D];
   logic [BW-1:0]      base_in [D];
   logic [BW-1:0]      len_ff  [D];
   logic [BW-1:0]      len_in  [D];
   logic [AW-1:0]      user_ff [D];
   logic [AW-1:0]      user_in [D];
   ffha_pkg::kind_type kind_ff [D];
   ffha_pkg::kind_type kind_in [D];
   logic [DW-1:0]      fl_ff   [D];
   logic [DW-1:0]      fl_in   [D];
   logic [DW-1:0]      al_ff   [D];
   logic [DW-1:0]      al_in   [D];
   logic [CW-1:0]      fcnt_ff, fcnt_in;
   logic [CW-1:0]      acnt_ff, acnt_in;

   // Sequencer
   ffha_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  r_ff, r_in;
   logic [CW-1:0]  rr_ff, rr_in;
   logic [DW-1:0]  c_ff, c_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [BW:0]    end_ff, end_in;
   logic [BW-1:0]  a_ff, a_in;
   logic [7:0]     pad_ff, pad_in;
   logic [15:0]    req_ff, req_in;
   logic [7:0]     align_ff, align_in;
   logic [15:0]    addr_ff, addr_in;

   // Result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_granted_ff, rsp_granted_in;

   // Shared datapath
   logic [DW-1:0] fl_at_r, fl_at_rr, al_at_p;
   logic [BW:0]   co_end_w;
   logic          co_match;
   logic [BW-1:0] fit_a_w;
   logic [7:0]    pad_w;
   logic [NW-1:0] need_w, user_w;
   logic          fits_w;
   logic          free_match;
   logic          spare_any;
   logic [DW-1:0] spare_idx;
   logic          cfg_wr;
   logic [BW-1:0] arena_sat;
   logic [4:0]    guard_sat;

   assign fl_at_r  = fl_ff[r_ff[DW-1:0]];
   assign fl_at_rr = fl_ff[rr_ff[DW-1:0]];
   assign al_at_p  = al_ff[rr_ff[DW-1:0]];

   assign co_end_w = {1'b0, base_ff[fl_at_r]} + {1'b0, len_ff[fl_at_r]};
   assign co_match = (fl_at_rr != c_ff) && ({1'b0, base_ff[fl_at_rr]} == end_ff);

   assign fit_a_w = base_ff[fl_at_r] + BW'(guard_ff);
   assign pad_w   = (~fit_a_w[7:0] + 8'd1) & (align_ff - 8'd1);
   assign need_w  = NW'(pad_ff) + NW'({guard_ff, 1'b0}) + NW'(req_ff);
   assign user_w  = NW'(a_ff) + NW'(pad_ff);
   assign fits_w  = (need_w <= NW'(len_ff[d_ff])) && ((user_w >> AW) == '0);

   assign free_match = (32'(user_ff[al_at_p]) == 32'(addr_ff));

   // Find the lowest spare descriptor
   always_comb begin
      spare_any = 1'b0;
      spare_idx = '0;
      for (int i = D - 1; i >= 0; i--) begin
         if (kind_ff[i] == ffha_pkg::KIND_SPARE) begin
            spare_any = 1'b1;
            spare_idx = DW'(i);
         end
      end
   end

   // Saturate register writes
   assign cfg_wr    = psel & penable & pwrite & pready;
   assign arena_sat = ({1'b0, pwdata} > (33'd1 << AW)) ? BW'(33'd1 << AW) : BW'(pwdata);
   assign guard_sat = (pwdata > 32'(ffha_pkg::GUARD_MAX)) ?
                      5'(ffha_pkg::GUARD_MAX) : pwdata[4:0];

   // Sequencer and list update
   always_comb begin
      arena_in = arena_ff;
      guard_in = guard_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      user_in  = user_ff;
      kind_in  = kind_ff;
      fl_in    = fl_ff;
      al_in    = al_ff;
      fcnt_in  = fcnt_ff;
      acnt_in  = acnt_ff;
      state_in = state_ff;
      r_in     = r_ff;
      rr_in    = rr_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      end_in   = end_ff;
      a_in     = a_ff;
      pad_in   = pad_ff;
      req_in   = req_ff;
      align_in = align_ff;
      addr_in  = addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;

      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (start) begin
               req_in   = req_request_bytes;
               align_in = req_alignment;
               addr_in  = req_user_address;
               r_in     = '0;
               rr_in    = '0;
               if (req_command == ffha_pkg::CMD_FREE) begin
                  state_in = ffha_pkg::S_FREE;
               end else if (req_alignment == 8'd0 ||
                            (req_alignment & (req_alignment - 8'd1)) != 8'd0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ffha_pkg::ST_BAD_ALIGN;
                  rsp_granted_in = '0;
               end else if (!spare_any) begin
                  state_in = ffha_pkg::S_CO_OUT;
               end else begin
                  state_in = ffha_pkg::S_FIT_A;
               end
            end
         end

         // Pick the block at merge rank r
         ffha_pkg::S_CO_OUT: begin
            if (r_ff >= fcnt_ff) begin
               r_in = '0;
               if (spare_any) begin
                  state_in = ffha_pkg::S_FIT_A;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ffha_pkg::ST_NO_DESC;
                  rsp_granted_in = '0;
                  state_in       = ffha_pkg::S_IDLE;
               end
            end else begin
               c_in     = fl_at_r;
               end_in   = co_end_w;
               rr_in    = '0;
               state_in = ffha_pkg::S_CO_IN;
            end
         end

         // Search its neighbor; absorb it and drop it from the list
         ffha_pkg::S_CO_IN: begin
            if (rr_ff >= fcnt_ff) begin
               r_in     = r_ff + 1'b1;
               state_in = ffha_pkg::S_CO_OUT;
            end else if (co_match) begin
               len_in[c_ff]     = len_ff[c_ff] + len_ff[fl_at_rr];
               kind_in[fl_at_rr] = ffha_pkg::KIND_SPARE;
               for (int i = 0; i < D - 1; i++) begin
                  if (CW'(i) >= rr_ff) fl_in[i] = fl_ff[i+1];
               end
               fcnt_in = fcnt_ff - 1'b1;
               if (rr_ff < r_ff) r_in = r_ff - 1'b1;
               state_in = ffha_pkg::S_CO_OUT;
            end else begin
               rr_in = rr_ff + 1'b1;
            end
         end

         // Align the candidate block
         ffha_pkg::S_FIT_A: begin
            if (r_ff >= fcnt_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffha_pkg::ST_NO_FIT;
               rsp_granted_in = '0;
               state_in       = ffha_pkg::S_IDLE;
            end else begin
               d_in     = fl_at_r;
               a_in     = fit_a_w;
               pad_in   = pad_w;
               state_in = ffha_pkg::S_FIT_B;
            end
         end

         // Test the fit and carve the front
         ffha_pkg::S_FIT_B: begin
            if (fits_w) begin
               kind_in[spare_idx] = ffha_pkg::KIND_ALLOC;
               base_in[spare_idx] = base_ff[d_ff];
               len_in[spare_idx]  = BW'(need_w);
               user_in[spare_idx] = AW'(user_w);
               al_in[acnt_ff[DW-1:0]] = spare_idx;
               acnt_in = acnt_ff + 1'b1;
               base_in[d_ff] = base_ff[d_ff] + BW'(need_w);
               len_in[d_ff]  = len_ff[d_ff] - BW'(need_w);
               if (NW'(len_ff[d_ff]) == need_w) begin
                  kind_in[d_ff] = ffha_pkg::KIND_SPARE;
                  for (int i = 0; i < D - 1; i++) begin
                     if (CW'(i) >= r_ff) fl_in[i] = fl_ff[i+1];
                  end
                  fcnt_in = fcnt_ff - 1'b1;
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffha_pkg::ST_OK;
               rsp_granted_in = 16'(user_w);
               state_in       = ffha_pkg::S_IDLE;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = ffha_pkg::S_FIT_A;
            end
         end

         // Walk the allocated list, oldest first
         ffha_pkg::S_FREE: begin
            if (rr_ff >= acnt_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffha_pkg::ST_NOT_ALLOC;
               rsp_granted_in = '0;
               state_in       = ffha_pkg::S_IDLE;
            end else if (free_match) begin
               for (int i = 0; i < D - 1; i++) begin
                  if (CW'(i) >= rr_ff) al_in[i] = al_ff[i+1];
               end
               acnt_in = acnt_ff - 1'b1;
               kind_in[al_at_p] = ffha_pkg::KIND_FREE;
               fl_in[fcnt_ff[DW-1:0]] = al_at_p;
               fcnt_in = fcnt_ff + 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffha_pkg::ST_OK;
               rsp_granted_in = '0;
               state_in       = ffha_pkg::S_IDLE;
            end else begin
               rr_in = rr_ff + 1'b1;
            end
         end

         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase

      // Register writes; an arena write restarts the pool
      if (cfg_wr) begin
         if (paddr[2] == ffha_pkg::REG_ARENA) begin
            arena_in = arena_sat;
            for (int i = 0; i < D; i++) kind_in[i] = ffha_pkg::KIND_SPARE;
            kind_in[0] = ffha_pkg::KIND_FREE;
            base_in[0] = '0;
            len_in[0]  = arena_sat;
            fl_in[0]   = '0;
            fcnt_in    = CW'(1);
            acnt_in    = '0;
         end else begin
            guard_in = guard_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      user_ff  <= user_in;
      al_ff    <= al_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      end_ff   <= end_in;
      a_ff     <= a_in;
      pad_ff   <= pad_in;
      req_ff   <= req_in;
      align_ff <= align_in;
      addr_ff  <= addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      if (reset) begin
         arena_ff <= BW'(ARENA_RST);
         guard_ff <= 5'(ffha_pkg::GUARD_RESET);
         for (int i = 0; i < D; i++) begin
            kind_ff[i] <= (i == 0) ? ffha_pkg::KIND_FREE : ffha_pkg::KIND_SPARE;
            base_ff[i] <= '0;
            len_ff[i]  <= (i == 0) ? BW'(ARENA_RST) : '0;
            fl_ff[i]   <= '0;
         end
         fcnt_ff    <= CW'(1);
         acnt_ff    <= '0;
         state_ff   <= ffha_pkg::S_IDLE;
         r_ff       <= '0;
         rr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arena_ff <= arena_in;
         guard_ff <= guard_in;
         kind_ff  <= kind_in;
         base_ff  <= base_in;
         len_ff   <= len_in;
         fl_ff    <= fl_in;
         fcnt_ff  <= fcnt_in;
         acnt_ff  <= acnt_in;
         state_ff <= state_in;
         r_ff     <= r_in;
         rr_ff    <= rr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Ports
   assign busy                = (state_ff != ffha_pkg::S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign pready              = 1'b1;
   assign prdata = (paddr[2] == ffha_pkg::REG_GUARD) ? 32'(guard_ff) : 32'(arena_ff);

   // Checks
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(fcnt_ff) + 32'(acnt_ff)) <= 32'(D))
      else $error("free and allocated lists exceed the pool");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ffha_pkg::ST_OK) |-> rsp_granted_ff == 16'd0)
      else $error("nonzero address on a failed item");

   a_bad_align: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == ffha_pkg::CMD_ALLOC) && (req_alignment == 8'd0)
      |=> rsp_valid_ff && (rsp_status_ff == ffha_pkg::ST_BAD_ALIGN))
      else $error("zero alignment not rejected at once");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ffha_pkg::S_IDLE)
      else $error("result strobe while the sequencer runs");

   a_state_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

endmodule
